>>> sv/tfso_pkg.sv
// tfso_pkg: shared types and constants of the tcp flow sequence offset table
// holds op and status codes, field widths and the per-entry request struct
// depends on nothing; imported by tfso_entry and tcp_flow_sequence_offset_table
package tfso_pkg;

  localparam int unsigned IpW    = 32;
  localparam int unsigned PortW  = 16;
  localparam int unsigned AddrW  = 2 * IpW;
  localparam int unsigned PairW  = 2 * PortW;
  localparam int unsigned DeltaW = 32;
  localparam int unsigned SizeW  = 17;
  localparam int unsigned PlenW  = 16;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_ADJUST  = 2'd1,
    OP_FETCH   = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_e;

  // bit 0 close-wait, bit 1 closed
  localparam logic [1:0] MarkCloseWait = 2'b01;
  localparam logic [1:0] MarkClosed    = 2'b10;

  // broadcast request from the lookup stage to every entry
  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [PairW-1:0]  port;
    logic              close_upd;  // observe with empty payload
    logic              fin;
    logic              rst;
    logic              adjust;
    logic              rev;
    logic              fetch;
    logic [DeltaW-1:0] size;       // sign extended size change
  } entry_req_t;

endpackage

>>> sv/tfso_entry.sv
// tfso_entry: one slot of the flow table, key compare plus its own deltas and close marks
// depends on tfso_pkg
module tfso_entry (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tfso_pkg::entry_req_t  req_i,
  input  logic                  alloc_i,
  output logic                  valid_o,
  output logic                  hit_o,
  output logic [31:0]           fwd_o,
  output logic [31:0]           rev_o
);
  import tfso_pkg::*;

  logic              valid_q, valid_d;
  logic [AddrW-1:0]  addr_q;
  logic [PairW-1:0]  port_q;
  logic [DeltaW-1:0] fwd_q, fwd_d;
  logic [DeltaW-1:0] rev_q, rev_d;
  logic [1:0]        marks_q, marks_d;
  logic              hit;

  assign hit = valid_q && (addr_q == req_i.addr) && (port_q == req_i.port);

  always_comb begin
    valid_d = valid_q;
    fwd_d   = fwd_q;
    rev_d   = rev_q;
    marks_d = marks_q;
    if (alloc_i) begin
      valid_d = 1'b1;
      fwd_d   = '0;
      rev_d   = '0;
      marks_d = '0;
    end else if (hit) begin
      if (req_i.close_upd) begin
        priority if (req_i.fin) begin
          marks_d = marks_q[0] ? (marks_q | MarkClosed) : (marks_q | MarkCloseWait);
        end else if (req_i.rst) begin
          marks_d = MarkCloseWait | MarkClosed;
        end else begin
          marks_d = marks_q;
        end
      end
      if (req_i.adjust) begin
        if (req_i.rev) begin
          rev_d = rev_q + req_i.size;
        end else begin
          fwd_d = fwd_q + req_i.size;
        end
      end
      // closed flow leaves the table once its offsets are read
      if (req_i.fetch && marks_q[1]) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      addr_q <= req_i.addr;
      port_q <= req_i.port;
    end
    fwd_q   <= fwd_d;
    rev_q   <= rev_d;
    marks_q <= marks_d;
  end

  assign valid_o = valid_q;
  assign hit_o   = hit;
  assign fwd_o   = fwd_q;
  assign rev_o   = rev_q;

endmodule

>>> sv/tcp_flow_sequence_offset_table.sv
// tcp_flow_sequence_offset_table: associative flow table for a packet rewriter
// holds the input register, the entry array with parallel compare and the result register
// depends on tfso_pkg and tfso_entry
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  command   | start_i / busy_o          | op, src/dst ip and port, fin, rst, payload
//            |                           | length, size change
//  result    | done_o (one-cycle strobe) | status, seq delta, ack delta
//
// every command gives exactly one result beat, through the input register, then
// lookup and update into the result register
// one command per cycle: the table is updated at the edge that captures the next
// command, so the next lookup always sees it; busy_o stays low
// reset empties the table at once through the per-entry valid flops, no sweep
// the receiver cannot stall, results are never held back
module tcp_flow_sequence_offset_table #(
  parameter int unsigned FLOW_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] src_ip_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] dst_port_i,
  input  logic        fin_flag_i,
  input  logic        rst_flag_i,
  input  logic [15:0] payload_length_i,
  input  logic signed [16:0] size_change_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] seq_delta_o,
  output logic [31:0] ack_delta_o
);
  import tfso_pkg::*;

  localparam logic [FLOW_ENTRIES-1:0] LowOne = {{(FLOW_ENTRIES-1){1'b0}}, 1'b1};

  // command side: the table takes a beat every cycle
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // canonical key: lower address first, ports break the tie
  logic              in_rev;
  logic [AddrW-1:0]  in_addr;
  logic [PairW-1:0]  in_port;

  assign in_rev  = (dst_ip_i < src_ip_i) ||
                   ((dst_ip_i == src_ip_i) && (dst_port_i < src_port_i));
  assign in_addr = in_rev ? {dst_ip_i, src_ip_i} : {src_ip_i, dst_ip_i};
  assign in_port = in_rev ? {dst_port_i, src_port_i} : {src_port_i, dst_port_i};

  // input register
  logic              vld_q;
  op_e               op_q;
  logic [AddrW-1:0]  addr_q;
  logic [PairW-1:0]  port_q;
  logic              rev_q;
  logic              fin_q;
  logic              rst_q;
  logic              plen_zero_q;
  logic [SizeW-1:0]  size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= op_e'(op_i);
      addr_q      <= in_addr;
      port_q      <= in_port;
      rev_q       <= in_rev;
      fin_q       <= fin_flag_i;
      rst_q       <= rst_flag_i;
      plen_zero_q <= (payload_length_i == '0);
      size_q      <= size_change_i;
    end
  end

  // decode of the registered command
  logic is_observe, is_adjust, is_fetch, size_nz;
  assign is_observe = vld_q && (op_q == OP_OBSERVE);
  assign is_adjust  = vld_q && (op_q == OP_ADJUST);
  assign is_fetch   = vld_q && (op_q == OP_FETCH);
  assign size_nz    = (size_q != '0);

  entry_req_t req;
  always_comb begin
    req.addr      = addr_q;
    req.port      = port_q;
    req.close_upd = is_observe && plen_zero_q;
    req.fin       = fin_q;
    req.rst       = rst_q;
    req.adjust    = is_adjust && size_nz;
    req.rev       = rev_q;
    req.fetch     = is_fetch;
    req.size      = {{(DeltaW-SizeW){size_q[SizeW-1]}}, size_q};
  end

  // entry array: every slot compares the key in parallel
  logic [FLOW_ENTRIES-1:0] valid_vec;
  logic [FLOW_ENTRIES-1:0] hit_vec;
  logic [FLOW_ENTRIES-1:0] alloc_vec;
  logic [DeltaW-1:0]       fwd_arr [FLOW_ENTRIES];
  logic [DeltaW-1:0]       rev_arr [FLOW_ENTRIES];

  // lowest free slot as a one-hot mask; zero when the table is full
  logic [FLOW_ENTRIES-1:0] free_vec, lowest_free;
  logic                    any_hit, table_full, create;

  assign free_vec    = ~valid_vec;
  assign lowest_free = free_vec & (~free_vec + LowOne);
  assign any_hit     = |hit_vec;
  assign table_full  = ~|free_vec;
  assign create      = is_observe && !any_hit && !fin_q && !rst_q && !table_full;
  assign alloc_vec   = create ? lowest_free : '0;

  for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_entry
    tfso_entry u_entry (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req),
      .alloc_i (alloc_vec[g]),
      .valid_o (valid_vec[g]),
      .hit_o   (hit_vec[g]),
      .fwd_o   (fwd_arr[g]),
      .rev_o   (rev_arr[g])
    );
  end

  // and-or read of the matching slot, at most one hit
  logic [DeltaW-1:0] hit_fwd, hit_rev;
  always_comb begin
    hit_fwd = '0;
    hit_rev = '0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      hit_fwd = hit_fwd | (fwd_arr[i] & {DeltaW{hit_vec[i]}});
      hit_rev = hit_rev | (rev_arr[i] & {DeltaW{hit_vec[i]}});
    end
  end

  // result of this beat
  status_e           status_d;
  logic [DeltaW-1:0] seq_d, ack_d;

  always_comb begin
    status_d = ST_OK;
    seq_d    = '0;
    ack_d    = '0;
    unique case (op_q)
      OP_OBSERVE: begin
        if (!any_hit) begin
          priority if (fin_q || rst_q) begin
            status_d = ST_NOT_FOUND;
          end else if (table_full) begin
            status_d = ST_TABLE_FULL;
          end else begin
            status_d = ST_OK;
          end
        end
      end
      OP_ADJUST: begin
        // a zero size change is taken without lookup
        if (size_nz && !any_hit) begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_FETCH: begin
        if (!any_hit) begin
          status_d = ST_NOT_FOUND;
        end else begin
          // reversed packet sees the deltas swapped
          seq_d = rev_q ? hit_rev : hit_fwd;
          ack_d = rev_q ? hit_fwd : hit_rev;
        end
      end
      OP_NOP: begin
        status_d = ST_OK;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // result register
  logic              done_q;
  status_e           status_q;
  logic [DeltaW-1:0] seq_q, ack_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      status_q <= status_d;
      seq_q    <= seq_d;
      ack_q    <= ack_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign seq_delta_o = seq_q;
  assign ack_delta_o = ack_q;

  // every registered command gives its result beat in the next cycle
  a_beat_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |=> done_o)
    else $error("command in lookup stage gave no result beat");

  // keys stay unique in the table
  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one entry matches the key");

  // a create fills one free slot and never one in use
  a_alloc_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(alloc_vec) && ((alloc_vec & valid_vec) == '0))
    else $error("allocation hit a busy slot or more than one slot");

  // a failed command shows no offsets: both deltas stay zero
  a_zero_deltas : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> ((seq_delta_o == '0) && (ack_delta_o == '0)))
    else $error("nonzero deltas on a failed command");

endmodule
